/* src/wclamp_pkg.sv */
// Shared types and constants for the winsorizing clamp block.
package wclamp_pkg;

    localparam int SAMPLE_W = 32;
    localparam int FRAC_W   = 16;

    localparam logic CFG_LOW_FRACTION  = 1'b0;
    localparam logic CFG_HIGH_FRACTION = 1'b1;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_RANK,
        ST_PICK,
        ST_EMIT,
        ST_ERROR
    } wclamp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;       // write the incoming sample and bump the count
        logic scan_start;  // clear i, j and the counters
        logic scan_step;   // compare stored[j] against stored[i]
        logic emit_start;  // clear emit index
        logic emit_step;   // load output register with next clamped sample
        logic error_load;  // load output register with the error result
        logic run_clear;   // reset the sample count
    } wclamp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic set_done;    // the stored sample ends the set
        logic frac_bad;    // fractions fail 0 < low < high
        logic scan_done;   // both thresholds found or all rows checked
        logic emit_last;   // output register holds the final result
        logic out_busy;    // always high in this datapath
    } wclamp_stat_t;

endpackage

/* src/winsorize_clamp.sv */
// Top level of the winsorizing clamp block: config registers, controller, datapath.
//
// The block stores up to MAX_SAMPLES signed 32-bit samples until a transaction with
// tlast high (or until the store fills), then finds the samples of rank
// floor(N*low_fraction/65536) and floor(N*high_fraction/65536) and emits every
// sample in input order clamped between them, with both thresholds on each result.
// If low_fraction is zero or not below high_fraction, one error result replaces
// the run. Input transactions are taken at one per cycle; after the last one the
// rank scan runs one compare per cycle through the single sample memory, stopping
// early once both ranks are found, followed by N output transactions at one per
// cycle when the sink is ready. No input is taken from the end of a set until the
// last result has been issued. m_axis_tuser holds the error flag and m_axis_tlast
// marks the final result of a run; configuration writes go through the cfg channel,
// index 0 for low_fraction and 1 for high_fraction. The user must write them only
// while idle; the block itself does not enforce it.
module winsorize_clamp
    import wclamp_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] sample
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // [31:0] clamped, [63:32] bottom, [95:64] top
    output logic         m_axis_tuser,   // [0] error
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [FRAC_W-1:0] low_reg, high_reg;
    wclamp_cmd_t  cmd;
    wclamp_stat_t stat;
    logic in_fire, out_take, out_valid, out_room;
    logic signed [SAMPLE_W-1:0] clamped, bt, tp;
    logic err, eor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= 16'd6554;
            high_reg <= 16'd58982;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOW_FRACTION:  low_reg  <= cfg_data;
                CFG_HIGH_FRACTION: high_reg <= cfg_data;
                default:           low_reg  <= low_reg;
            endcase
        end
    end

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_take = out_valid && m_axis_tready;
    // The output register can take a new result when empty or being drained.
    assign out_room = !out_valid || m_axis_tready;

    wclamp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_room (out_room),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    wclamp_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .sample           (s_axis_tdata),
        .last             (s_axis_tlast),
        .low_fraction     (low_reg),
        .high_fraction    (high_reg),
        .out_take         (out_take),
        .out_valid        (out_valid),
        .clamped          (clamped),
        .bottom_threshold (bt),
        .top_threshold    (tp),
        .error            (err),
        .end_of_run       (eor)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {tp, bt, clamped};
    assign m_axis_tuser  = err;
    assign m_axis_tlast  = eor;

endmodule

/* src/wclamp_ctrl.sv */
// Controller state machine for the winsorizing clamp block.
module wclamp_ctrl
    import wclamp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_fire,
    input  logic         out_room,
    input  wclamp_stat_t stat,
    output wclamp_cmd_t  cmd,
    output logic         in_ready
);

    wclamp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.store = 1'b1;
                    if (stat.set_done)
                    begin
                        state_next = ST_RANK;
                    end
                end
            end
            ST_RANK:
            begin
                if (stat.frac_bad)
                begin
                    state_next = ST_ERROR;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (stat.scan_done)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_room)
                begin
                    if (stat.emit_last && stat.out_busy)
                    begin
                        cmd.run_clear = 1'b1;
                        state_next    = ST_COLLECT;
                    end
                    else
                    begin
                        cmd.emit_step = 1'b1;
                    end
                end
            end
            ST_ERROR:
            begin
                if (out_room)
                begin
                    cmd.error_load = 1'b1;
                    cmd.run_clear  = 1'b1;
                    state_next     = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

endmodule

/* src/wclamp_dp.sv */
// Datapath for the winsorizing clamp block: sample memory, rank scan, clamp.
module wclamp_dp
    import wclamp_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  wclamp_cmd_t                cmd,
    output wclamp_stat_t               stat,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,
    input  logic        [FRAC_W-1:0]   low_fraction,
    input  logic        [FRAC_W-1:0]   high_fraction,
    input  logic                       out_take,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] clamped,
    output logic signed [SAMPLE_W-1:0] bottom_threshold,
    output logic signed [SAMPLE_W-1:0] top_threshold,
    output logic                       error,
    output logic                       end_of_run
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, j_reg, emit_reg;
    logic [CW-1:0] below_reg, same_reg;
    logic [CW-1:0] lo_rank_reg, hi_rank_reg;
    logic          lo_found_reg, hi_found_reg;
    logic signed [SAMPLE_W-1:0] lo_val_reg, hi_val_reg;
    logic signed [SAMPLE_W-1:0] rd_i_reg, rd_j_reg;
    logic          cmp_valid_reg;
    logic          row_end_reg;

    logic [CW+FRAC_W-1:0] lo_prod, hi_prod;

    logic          out_valid_reg;
    logic signed [SAMPLE_W-1:0] clamped_reg, bt_reg, tp_reg;
    logic          error_reg, eor_reg, final_reg;

    // Shared read port: row sample during the scan, next sample to emit afterwards.
    logic          scan_rd;
    logic          rd_a_en;
    logic [AW-1:0] rd_a_addr;
    logic [CW-1:0] emit_next;

    assign count_next = count_reg + CW'(1);
    assign emit_next  = emit_reg + CW'(1);
    assign scan_rd    = cmd.scan_step && (i_reg < count_reg);
    assign rd_a_en    = scan_rd || cmd.emit_start || cmd.emit_step;

    always_comb
    begin
        rd_a_addr = i_reg[AW-1:0];
        if (cmd.emit_start)
        begin
            rd_a_addr = '0;
        end
        else if (cmd.emit_step)
        begin
            rd_a_addr = emit_next[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[count_reg[AW-1:0]] <= sample;
        end
        if (rd_a_en)
        begin
            rd_i_reg <= mem[rd_a_addr];
        end
        if (scan_rd)
        begin
            rd_j_reg <= mem[j_reg[AW-1:0]];
        end
    end

    assign stat.set_done = last || (count_next == CW'(MAX_SAMPLES));
    assign stat.frac_bad = (low_fraction == '0) || (low_fraction >= high_fraction);

    assign lo_prod = count_reg * low_fraction;
    assign hi_prod = count_reg * high_fraction;

    // Rank scan: one compare a cycle over the pair (i, j), a reads pipeline stage ahead.
    logic          row_close;
    logic [CW-1:0] below_n, same_n;
    logic          less_n, eq_n;

    always_comb
    begin
        less_n  = rd_j_reg < rd_i_reg;
        eq_n    = rd_j_reg == rd_i_reg;
        below_n = below_reg + CW'(less_n);
        same_n  = same_reg + CW'(eq_n && !less_n);
    end

    assign row_close = cmp_valid_reg && row_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            emit_reg      <= '0;
            below_reg     <= '0;
            same_reg      <= '0;
            lo_found_reg  <= 1'b0;
            hi_found_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            row_end_reg   <= 1'b0;
            lo_rank_reg   <= '0;
            hi_rank_reg   <= '0;
            lo_val_reg    <= '0;
            hi_val_reg    <= '0;
            out_valid_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.store)
            begin
                count_reg <= count_next;
            end
            if (cmd.run_clear)
            begin
                count_reg <= '0;
            end

            cmp_valid_reg <= 1'b0;
            if (cmd.scan_start)
            begin
                i_reg        <= '0;
                j_reg        <= '0;
                below_reg    <= '0;
                same_reg     <= '0;
                lo_found_reg <= 1'b0;
                hi_found_reg <= 1'b0;
                lo_rank_reg  <= lo_prod[CW+FRAC_W-1:FRAC_W];
                hi_rank_reg  <= hi_prod[CW+FRAC_W-1:FRAC_W];
            end
            else if (cmd.scan_step)
            begin
                if (cmp_valid_reg)
                begin
                    below_reg <= below_n;
                    same_reg  <= same_n;
                end
                if (row_close)
                begin
                    below_reg <= '0;
                    same_reg  <= '0;
                    if (!lo_found_reg && below_n <= lo_rank_reg
                        && lo_rank_reg < below_n + same_n)
                    begin
                        lo_found_reg <= 1'b1;
                        lo_val_reg   <= rd_i_reg;
                    end
                    if (!hi_found_reg && below_n <= hi_rank_reg
                        && hi_rank_reg < below_n + same_n)
                    begin
                        hi_found_reg <= 1'b1;
                        hi_val_reg   <= rd_i_reg;
                    end
                end
                if (scan_rd)
                begin
                    cmp_valid_reg <= 1'b1;
                    row_end_reg   <= (j_reg + CW'(1)) == count_reg;
                    if ((j_reg + CW'(1)) == count_reg)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + CW'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
            end

            if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit_start)
            begin
                emit_reg  <= '0;
                final_reg <= 1'b0;
            end
            if (cmd.emit_step)
            begin
                out_valid_reg <= 1'b1;
                emit_reg      <= emit_next;
                final_reg     <= emit_next == count_reg;
            end
            if (cmd.error_load)
            begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.run_clear)
            begin
                final_reg <= 1'b0;
            end
        end
    end

    // The rank scan is done when both values are found or all rows are checked.
    assign stat.scan_done = (lo_found_reg && hi_found_reg)
                            || (i_reg == count_reg && !cmp_valid_reg);

    // Output register payload; loaded from a registered memory read.
    logic signed [SAMPLE_W-1:0] v;
    always_comb
    begin
        v = rd_i_reg;
        if (v < lo_val_reg)
        begin
            v = lo_val_reg;
        end
        else if (hi_val_reg < v)
        begin
            v = hi_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            clamped_reg <= v;
            bt_reg      <= lo_val_reg;
            tp_reg      <= hi_val_reg;
            error_reg   <= 1'b0;
            eor_reg     <= emit_next == count_reg;
        end
        if (cmd.error_load)
        begin
            clamped_reg <= '0;
            bt_reg      <= '0;
            tp_reg      <= '0;
            error_reg   <= 1'b1;
            eor_reg     <= 1'b1;
        end
    end

    assign stat.emit_last = final_reg;
    assign stat.out_busy  = 1'b1;

    assign out_valid        = out_valid_reg;
    assign clamped          = clamped_reg;
    assign bottom_threshold = bt_reg;
    assign top_threshold    = tp_reg;
    assign error            = error_reg;
    assign end_of_run       = eor_reg;

    a_store_only_below_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> count_reg < CW'(MAX_SAMPLES))
        else $error("store beyond capacity");
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_step && cmd.error_load))
        else $error("two loads of the output register");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_take) |-> !(cmd.emit_step || cmd.error_load))
        else $error("result overwritten before it was taken");
    a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |=> out_valid_reg)
        else $error("load did not raise valid");

endmodule

/* bench/tb_winsorize_clamp.sv */
// Testbench for the winsorizing clamp block: directed and random sets checked by a predictor.
`timescale 1ns / 1ps

module tb_winsorize_clamp;
    import wclamp_pkg::*;

    localparam int DEPTH      = 64;
    localparam int CYCLE_CAP  = 2000000;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } sample_item_t;

    typedef struct packed {
        logic [31:0] clamped;
        logic [31:0] bottom;
        logic [31:0] top;
        logic        error;
        logic        end_of_run;
    } clamp_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_LOW_FRACTION;
    logic [15:0] cfg_data = '0;

    winsorize_clamp #(.MAX_SAMPLES(DEPTH)) dut (.*);

    always #6 clk = ~clk;

    // Predictor state: shadow of the sample store and the two fractions.
    logic [31:0] set_buf[DEPTH];
    int unsigned set_len = 0;
    logic [15:0] low_frac = 16'd6554;
    logic [15:0] high_frac = 16'd58982;

    sample_item_t  pending_samples[$];
    clamp_result_t expected_results[$];
    int            mismatches = 0;
    int            send_idle_pct = 14;
    int            recv_idle_pct = 48;
    longint        cycles = 0;

    // The accept seen at the last rising edge, so the driver moves on only after a transaction.
    logic s_axis_tready_q = 1'b0;

    // Order statistic of rank k among the stored samples; ties return the shared value.
    function automatic logic [31:0] pick_rank(int unsigned n, int unsigned k);
        int unsigned below;
        int unsigned same;
        for (int i = 0; i < n; i++) begin
            below = 0;
            same = 0;
            for (int j = 0; j < n; j++) begin
                if ($signed(set_buf[j]) < $signed(set_buf[i]))
                    below++;
                else if (set_buf[j] == set_buf[i])
                    same++;
            end
            if (below <= k && k < below + same)
                return set_buf[i];
        end
        return '0;
    endfunction

    // Predict the results caused by one accepted sample transaction.
    function automatic void predict_winsorize(sample_item_t it);
        clamp_result_t r;
        logic [31:0]   lo_v;
        logic [31:0]   hi_v;
        int unsigned   n;
        if (set_len < DEPTH) begin
            set_buf[set_len] = it.sample;
            set_len++;
        end
        if (!it.last && set_len < DEPTH)
            return;
        n = set_len;
        set_len = 0;
        if (low_frac == 0 || low_frac >= high_frac) begin
            r = '{clamped: '0, bottom: '0, top: '0, error: 1'b1, end_of_run: 1'b1};
            expected_results.push_back(r);
            return;
        end
        lo_v = pick_rank(n, (n * low_frac) >> 16);
        hi_v = pick_rank(n, (n * high_frac) >> 16);
        for (int i = 0; i < n; i++) begin
            r.clamped = set_buf[i];
            if ($signed(r.clamped) < $signed(lo_v))
                r.clamped = lo_v;
            else if ($signed(hi_v) < $signed(r.clamped))
                r.clamped = hi_v;
            r.bottom = lo_v;
            r.top = hi_v;
            r.error = 1'b0;
            r.end_of_run = (i + 1 == n);
            expected_results.push_back(r);
        end
    endfunction

    // Driver: presents queued samples at the falling edge, idling at random.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_axis_tvalid || s_axis_tready_q) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_samples[0].sample;
                    s_axis_tlast <= pending_samples[0].last;
                    void'(pending_samples.pop_front());
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: samples both streams at the rising edge, predicts and checks.
    always @(posedge clk) begin
        clamp_result_t got;
        clamp_result_t want;
        cycles <= cycles + 1;
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            predict_winsorize('{sample: s_axis_tdata, last: s_axis_tlast});
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{clamped: m_axis_tdata[31:0], bottom: m_axis_tdata[63:32],
                    top: m_axis_tdata[95:64], error: m_axis_tuser,
                    end_of_run: m_axis_tlast};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", got);
            end
            else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected clamped %h bottom %h top %h err %b",
                                  " eor %b, got clamped %h bottom %h top %h err %b eor %b"},
                                 want.clamped, want.bottom, want.top, want.error,
                                 want.end_of_run, got.clamped, got.bottom, got.top,
                                 got.error, got.end_of_run);
                end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_LOW_FRACTION)
            low_frac = value;
        else
            high_frac = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until all queued samples went in and every result came out, then let the scan settle.
    task automatic drain();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH * DEPTH + 20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(7);
            3: return 32'hFFFF_FFF8 + $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // Queue one set of n samples; a full set of DEPTH needs no last mark.
    task automatic queue_set(int n, bit mark_last);
        for (int i = 0; i < n; i++)
            pending_samples.push_back('{sample: rand_sample(),
                                        last: (i == n - 1) ? mark_last : 1'b0});
    endtask

    initial begin
        int n;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, duplicates, single sample, bad fractions, full store without last.
        pending_samples.push_back('{32'h8000_0000, 1'b0});
        pending_samples.push_back('{32'h7FFF_FFFF, 1'b0});
        pending_samples.push_back('{32'h0000_0000, 1'b0});
        pending_samples.push_back('{32'hFFFF_FFFF, 1'b1});
        pending_samples.push_back('{32'h0000_0005, 1'b1});
        for (int i = 0; i < 6; i++)
            pending_samples.push_back('{32'h0000_0007, i == 5});
        drain();
        write_reg(CFG_LOW_FRACTION, 16'd0);
        queue_set(3, 1'b1);
        drain();
        write_reg(CFG_LOW_FRACTION, 16'd60000);
        write_reg(CFG_HIGH_FRACTION, 16'd60000);
        queue_set(2, 1'b1);
        drain();
        write_reg(CFG_LOW_FRACTION, 16'd1);
        write_reg(CFG_HIGH_FRACTION, 16'hFFFF);
        queue_set(DEPTH, 1'b0);
        drain();

        // Random phases with different fraction settings and idling patterns.
        for (int phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 14 : (phase < 4) ? 48 : 0;
            recv_idle_pct = (phase < 2) ? 48 : (phase < 4) ? 14 : 0;
            case (phase)
                0: begin write_reg(CFG_LOW_FRACTION, 16'd6554);
                         write_reg(CFG_HIGH_FRACTION, 16'd58982); end
                1: begin write_reg(CFG_LOW_FRACTION, 16'hFFFE);
                         write_reg(CFG_HIGH_FRACTION, 16'hFFFF); end
                2: begin write_reg(CFG_LOW_FRACTION, 16'd16384);
                         write_reg(CFG_HIGH_FRACTION, 16'd49152); end
                3: begin write_reg(CFG_LOW_FRACTION, 16'($urandom_range(1, 32767)));
                         write_reg(CFG_HIGH_FRACTION, 16'($urandom_range(32768, 65535))); end
                4: begin write_reg(CFG_LOW_FRACTION, 16'($urandom_range(1, 65535)));
                         write_reg(CFG_HIGH_FRACTION, 16'($urandom_range(1, 65535))); end
                default: begin write_reg(CFG_LOW_FRACTION, 16'd1);
                               write_reg(CFG_HIGH_FRACTION, 16'd2); end
            endcase
            for (int s = 0; s < 4; s++) begin
                n = ($urandom_range(9) == 0) ? DEPTH : $urandom_range(1, 10);
                queue_set(n, (n == DEPTH) ? $urandom_range(1) : 1'b1);
            end
            drain();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

/* files.f */
src/wclamp_pkg.sv
src/wclamp_ctrl.sv
src/wclamp_dp.sv
src/winsorize_clamp.sv
bench/tb_winsorize_clamp.sv
